[hdl/krt_pkg.sv]
// shared types and constants for the keyed record table
`default_nettype none

package krt_pkg;

    localparam int CW       = 7;   // entry count and capacity width
    localparam int KW       = 32;  // key width
    localparam int PW       = 32;  // payload width
    localparam int POSW     = 6;   // reported position width
    localparam int LIST_MAX = 64;  // most records one list transaction emits

    localparam logic [CW-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_LIST   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_DUP     = 3'd2,
        ST_MISSING = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef struct packed {
        t_op                   op;
        logic signed [KW-1:0]  key;
        logic [PW-1:0]         payload;
    } t_cmd;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qlink;

endpackage

`default_nettype wire

[hdl/krt_front.sv]
// front end: takes request transactions, decodes them and queues them
`default_nettype none

module krt_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_op,
    input  logic signed [krt_pkg::KW-1:0]     i_key,
    input  logic [krt_pkg::PW-1:0]            i_payload_in,
    output krt_pkg::t_qlink                   o_q,
    input  logic                              i_pop
);
    import krt_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic [1:0] n_fill;
    logic       push;
    logic       pop;
    t_cmd       in_cmd;

    always_comb begin
        in_cmd.op      = t_op'(i_op);
        in_cmd.key     = i_key;
        in_cmd.payload = i_payload_in;
    end

    assign o_stall = (r_fill == 2'd2);
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_fill != 2'd0);

    always_comb begin
        case ({push, pop})
            2'b10:   n_fill = r_fill + 2'd1;
            2'b01:   n_fill = r_fill - 2'd1;
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= in_cmd;
        end
    end

    assign o_q.valid = (r_fill != 2'd0);
    assign o_q.cmd   = r_slot[r_rd_ptr];

endmodule

`default_nettype wire

[hdl/krt_back.sv]
// back end: table memory, linear search sequencer and result register
`default_nettype none

module krt_back #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [krt_pkg::CW-1:0]            i_capacity,
    input  krt_pkg::t_qlink                   i_q,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_status,
    output logic signed [krt_pkg::KW-1:0]     o_key_out,
    output logic [krt_pkg::PW-1:0]            o_payload_out,
    output logic [krt_pkg::POSW-1:0]          o_position,
    output logic                              o_last
);
    import krt_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int DLIM_I = (DEPTH > (2**CW) - 1) ? (2**CW) - 1 : DEPTH;
    localparam logic [CW-1:0] DEPTH_LIM = CW'(DLIM_I);
    localparam logic [CW-1:0] LIST_LIM  = CW'(LIST_MAX);

    typedef struct packed {
        t_status               status;
        logic signed [KW-1:0]  key;
        logic [PW-1:0]         payload;
        logic [POSW-1:0]       pos;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MOVE_RD,
        S_MOVE_WR,
        S_EMIT,
        S_LIST
    } t_state;

    function automatic t_res mk_res(input t_status s, input logic [KW-1:0] k,
                                    input logic [PW-1:0] p,
                                    input logic [POSW-1:0] q);
        t_res r;
        r.status  = s;
        r.key     = k;
        r.payload = p;
        r.pos     = q;
        return r;
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] v);
        logic [AW+CW-1:0] w;
        w = {{AW{1'b0}}, v};
        return w[AW-1:0];
    endfunction

    logic [KW-1:0] r_key_mem [DEPTH];
    logic [PW-1:0] r_pay_mem [DEPTH];
    logic [KW-1:0] r_rd_key;
    logic [PW-1:0] r_rd_pay;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    t_cmd          r_cmd, n_cmd;
    t_res          r_res, n_res;
    t_res          r_out, n_out;
    logic          r_out_valid, n_out_valid;
    logic          r_out_last, n_out_last;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_key;
    logic [PW-1:0] wr_pay;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] limit;
    logic [CW-1:0] list_n;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] idx_p1;
    logic          hit;
    logic          out_free;

    assign limit    = (i_capacity < DEPTH_LIM) ? i_capacity : DEPTH_LIM;
    assign list_n   = (r_count < LIST_LIM) ? r_count : LIST_LIM;
    assign count_m1 = r_count - CW'(1);
    assign idx_p1   = r_idx + CW'(1);
    assign hit      = (r_rd_key == r_cmd.key);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_res       = r_res;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && i_stall;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = to_addr(r_count);
        wr_key      = r_cmd.key;
        wr_pay      = r_cmd.payload;
        rd_addr     = '0;

        case (r_state)
            S_IDLE: begin
                // entry 0 is always being read so a search or list starts at once
                if (i_q.valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_q.cmd;
                    n_idx = '0;
                    if (i_q.cmd.op == OP_INSERT) begin
                        if (r_count >= limit) begin
                            n_res   = mk_res(ST_FULL, '0, '0, '0);
                            n_state = S_EMIT;
                        end else if (r_count == '0) begin
                            wr_en   = 1'b1;
                            wr_key  = i_q.cmd.key;
                            wr_pay  = i_q.cmd.payload;
                            n_count = CW'(1);
                            n_res   = mk_res(ST_OK, i_q.cmd.key, i_q.cmd.payload, '0);
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_SEARCH;
                        end
                    end else if (r_count == '0) begin
                        n_res   = mk_res(ST_EMPTY, '0, '0, '0);
                        n_state = S_EMIT;
                    end else if (i_q.cmd.op == OP_LIST) begin
                        n_state = S_LIST;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // r_rd holds entry r_idx, the next entry is being fetched
                rd_addr = to_addr(idx_p1);
                if (hit) begin
                    n_res = mk_res((r_cmd.op == OP_INSERT) ? ST_DUP : ST_OK,
                                   r_rd_key, r_rd_pay, r_idx[POSW-1:0]);
                    n_state = (r_cmd.op == OP_DELETE) ? S_MOVE_RD : S_EMIT;
                end else if (r_idx == count_m1) begin
                    if (r_cmd.op == OP_INSERT) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                        n_res   = mk_res(ST_OK, r_cmd.key, r_cmd.payload,
                                         r_count[POSW-1:0]);
                    end else begin
                        n_res = mk_res(ST_MISSING, '0, '0, '0);
                    end
                    n_state = S_EMIT;
                end else begin
                    n_idx = idx_p1;
                end
            end
            S_MOVE_RD: begin
                rd_addr = to_addr(count_m1);
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                // last record fills the hole left by the deleted one
                if (r_idx != count_m1) begin
                    wr_en   = 1'b1;
                    wr_addr = to_addr(r_idx);
                    wr_key  = r_rd_key;
                    wr_pay  = r_rd_pay;
                end
                n_count = count_m1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_LIST: begin
                rd_addr = to_addr(r_idx);
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = mk_res(ST_OK, r_rd_key, r_rd_pay, r_idx[POSW-1:0]);
                    n_out_last  = (idx_p1 == list_n);
                    n_idx       = idx_p1;
                    rd_addr     = to_addr(idx_p1);
                    if (idx_p1 == list_n) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cmd      <= n_cmd;
        r_res      <= n_res;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_mem[wr_addr] <= wr_key;
            r_pay_mem[wr_addr] <= wr_pay;
        end
        r_rd_key <= r_key_mem[rd_addr];
        r_rd_pay <= r_pay_mem[rd_addr];
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_key_out     = r_out.key;
    assign o_payload_out = r_out.payload;
    assign o_position    = r_out.pos;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

[hdl/keyed_record_table_unit.sv]
// keyed record table: insert, lookup, delete and list over a packed unsorted table
// insert, lookup, delete: a linear search from entry 0, since the single-read-port table
//   memory yields one entry per cycle; delete then moves the last record into the hole;
//   a full insert, a first insert or an empty table needs no search
// list: one record per cycle while the receiver does not stall
// up to two requests wait in the front queue while the back end works
// reset clears the entry count and sets capacity to 64; table contents are not cleared
`default_nettype none

module keyed_record_table_unit #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_op,
    input  logic signed [krt_pkg::KW-1:0]     i_key,
    input  logic [krt_pkg::PW-1:0]            i_payload_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_status,
    output logic signed [krt_pkg::KW-1:0]     o_key_out,
    output logic [krt_pkg::PW-1:0]            o_payload_out,
    output logic [krt_pkg::POSW-1:0]          o_position,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [krt_pkg::CW-1:0]            i_cfg_wdata
);
    import krt_pkg::*;

    logic [CW-1:0] r_capacity;
    t_qlink        q_link;
    logic          q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    krt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_key        (i_key),
        .i_payload_in (i_payload_in),
        .o_q          (q_link),
        .i_pop        (q_pop)
    );

    krt_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_capacity    (r_capacity),
        .i_q           (q_link),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_key_out     (o_key_out),
        .o_payload_out (o_payload_out),
        .o_position    (o_position),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

[hdl/krt_checker.sv]
// port-level checks on the result channel of the keyed record table
`default_nettype none

module krt_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic [2:0]                        o_status,
    input  logic signed [krt_pkg::KW-1:0]     o_key_out,
    input  logic [krt_pkg::PW-1:0]            o_payload_out,
    input  logic [krt_pkg::POSW-1:0]          o_position,
    input  logic                              o_last
);
    import krt_pkg::*;

    // full, not found and empty carry no record and end the transaction
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL || o_status == ST_MISSING || o_status == ST_EMPTY)
        |-> o_key_out == '0 && o_payload_out == '0 && o_position == '0 && o_last)
        else $error("error result with record fields or without last");

    // only list records can be non-final, and they are all ok
    a_nonlast_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_status == ST_OK)
        else $error("non-final result with error status");

    // list records follow back to back with rising positions
    a_list_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last
        |=> o_valid && o_position == $past(o_position) + 6'd1)
        else $error("list record missing or out of order");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall
        |=> o_valid && $stable(o_key_out) && $stable(o_position) && $stable(o_status))
        else $error("stalled result changed");

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (.*);

`default_nettype wire

[test/keyed_record_table_unit_test.sv]
// self-checking testbench for the keyed record table unit
`timescale 1ns / 1ps

module keyed_record_table_unit_test;
    import krt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        t_status               status;
        logic signed [KW-1:0]  key;
        logic [PW-1:0]         payload;
        logic [POSW-1:0]       position;
        logic                  last;
    } t_table_result;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    t_cmd            in_cmd = '0;
    logic            out_stall = 1'b1;
    logic            cfg_we = 1'b0;
    logic [CW-1:0]   cfg_wdata = '0;

    wire             dut_stall;
    wire             res_valid;
    wire [2:0]       res_status;
    wire signed [KW-1:0] res_key;
    wire [PW-1:0]    res_payload;
    wire [POSW-1:0]  res_position;
    wire             res_last;

    keyed_record_table_unit #(.DEPTH(TABLE_DEPTH)) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (dut_stall),
        .i_op          (in_cmd.op),
        .i_key         (in_cmd.key),
        .i_payload_in  (in_cmd.payload),
        .o_valid       (res_valid),
        .i_stall       (out_stall),
        .o_status      (res_status),
        .o_key_out     (res_key),
        .o_payload_out (res_payload),
        .o_position    (res_position),
        .o_last        (res_last),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // table model state
    logic [CW-1:0]   capacity_reg = CAP_RESET;
    int              table_count = 0;
    logic [KW-1:0]   key_table [0:TABLE_DEPTH-1];
    logic [PW-1:0]   payload_table [0:TABLE_DEPTH-1];

    t_table_result   expected_results [$];
    t_cmd            pending_cmds [$];
    logic signed [KW-1:0] key_pool [$];

    int  fail_count = 0;
    int  items_accepted = 0;
    int  results_checked = 0;
    int  lists_accepted = 0;
    int  cycle_count = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  gap_left = 0;
    bit  gap_free = 1'b0;
    bit  stall_free = 1'b0;
    logic in_taken = 1'b0;
    t_table_result want;

    function automatic void push_result(input t_status status, input logic [KW-1:0] key,
                                        input logic [PW-1:0] payload, input int position,
                                        input logic last);
        t_table_result r;
        r.status   = status;
        r.key      = key;
        r.payload  = payload;
        r.position = position[POSW-1:0];
        r.last     = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_transaction(input t_cmd cmd);
        int limit;
        int hit_idx;
        int i;
        limit = (int'(capacity_reg) > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity_reg);
        hit_idx = -1;
        for (i = 0; i < table_count; i++) begin
            if (hit_idx < 0 && key_table[i] == cmd.key) hit_idx = i;
        end
        if (cmd.op == OP_INSERT) begin
            // full takes priority over duplicate
            if (table_count >= limit) begin
                push_result(ST_FULL, '0, '0, 0, 1'b1);
            end else if (hit_idx >= 0) begin
                push_result(ST_DUP, key_table[hit_idx], payload_table[hit_idx], hit_idx, 1'b1);
            end else begin
                key_table[table_count]     = cmd.key;
                payload_table[table_count] = cmd.payload;
                push_result(ST_OK, cmd.key, cmd.payload, table_count, 1'b1);
                table_count++;
            end
        end else if (table_count == 0) begin
            push_result(ST_EMPTY, '0, '0, 0, 1'b1);
        end else if (cmd.op == OP_LIST) begin
            for (i = 0; i < table_count && i < LIST_MAX; i++) begin
                push_result(ST_OK, key_table[i], payload_table[i], i,
                            (i + 1 == table_count || i + 1 == LIST_MAX));
            end
        end else if (hit_idx < 0) begin
            push_result(ST_MISSING, '0, '0, 0, 1'b1);
        end else begin
            push_result(ST_OK, key_table[hit_idx], payload_table[hit_idx], hit_idx, 1'b1);
            if (cmd.op == OP_DELETE) begin
                // last record fills the hole
                key_table[hit_idx]     = key_table[table_count-1];
                payload_table[hit_idx] = payload_table[table_count-1];
                table_count--;
            end
        end
    endfunction

    function automatic int pick_run();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic int pick_gap();
        if (gap_free || $urandom_range(0, 99) < 55) return 0;
        return pick_run();
    endfunction

    // driver: accept side sampled at the rising edge
    always @(posedge clk) begin
        if (rst_n && in_valid && !dut_stall) begin
            predict_transaction(in_cmd);
            items_accepted++;
            if (in_cmd.op == OP_LIST) lists_accepted++;
        end
        in_taken <= rst_n && in_valid && !dut_stall;
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                in_cmd   <= pending_cmds.pop_front();
                in_valid <= 1'b1;
                gap_left <= pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with an occasional long hold
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            out_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (!stall_free && $urandom_range(0, 99) < 25) begin
            stall_left <= pick_run() - 1;
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    // monitor
    always @(posedge clk) begin
        if (rst_n && res_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d key %h position %0d",
                         $time, res_status, res_key, res_position);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(res_status));
                check_field("key_out", want.key, res_key);
                check_field("payload_out", want.payload, res_payload);
                check_field("position", 32'(want.position), 32'(res_position));
                check_field("last", 32'(want.last), 32'(res_last));
                results_checked++;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic queue_cmd(input t_op op, input logic signed [KW-1:0] key,
                             input logic [PW-1:0] payload);
        t_cmd c;
        c.op      = op;
        c.key     = key;
        c.payload = payload;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_random(input int count, input int ins_pct, input int del_pct,
                                input int list_pct);
        int n;
        int roll;
        t_op op_pick;
        logic signed [KW-1:0] key_pick;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct) op_pick = OP_INSERT;
            else if (roll < ins_pct + del_pct) op_pick = OP_DELETE;
            else if (roll < ins_pct + del_pct + list_pct) op_pick = OP_LIST;
            else op_pick = OP_LOOKUP;
            if (key_pool.size() > 0 && $urandom_range(0, 99) < 85)
                key_pick = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
                key_pick = $urandom;
            queue_cmd(op_pick, key_pick, $urandom);
        end
    endtask

    task automatic refresh_pool(input int count);
        int n;
        key_pool.delete();
        key_pool.push_back(32'sh8000_0000);
        key_pool.push_back(32'sh7fff_ffff);
        key_pool.push_back(32'sh0000_0000);
        key_pool.push_back(-32'sd1);
        for (n = 0; n < count; n++) key_pool.push_back($urandom);
    endtask

    // pause the sender until the block has delivered everything
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CW-1:0] value);
        @(negedge clk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= value;
        capacity_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int n;
        logic signed [KW-1:0] fresh_key;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, extreme keys, duplicate, swap-on-delete
        queue_cmd(OP_LOOKUP, 32'sd5, 32'h0);
        queue_cmd(OP_DELETE, 32'sd5, 32'h0);
        queue_cmd(OP_LIST, 32'sd0, 32'h0);
        queue_cmd(OP_INSERT, 32'sh8000_0000, 32'h0000_0000);
        queue_cmd(OP_INSERT, 32'sh7fff_ffff, 32'hffff_ffff);
        queue_cmd(OP_INSERT, 32'sh0000_0000, 32'ha5a5_a5a5);
        queue_cmd(OP_INSERT, -32'sd1, 32'h5a5a_5a5a);
        queue_cmd(OP_INSERT, 32'sh7fff_ffff, 32'h0000_0001);
        queue_cmd(OP_LOOKUP, 32'sh8000_0000, 32'h0);
        queue_cmd(OP_LOOKUP, -32'sd1, 32'h0);
        queue_cmd(OP_LOOKUP, 32'sd12345, 32'h0);
        queue_cmd(OP_LIST, 32'sd0, 32'h0);
        queue_cmd(OP_DELETE, 32'sh8000_0000, 32'h0);
        queue_cmd(OP_LOOKUP, -32'sd1, 32'h0);
        queue_cmd(OP_DELETE, -32'sd1, 32'h0);
        queue_cmd(OP_DELETE, 32'sh7fff_ffff, 32'h0);
        queue_cmd(OP_DELETE, 32'sd777, 32'h0);
        queue_cmd(OP_LIST, 32'sd0, 32'h0);
        queue_cmd(OP_DELETE, 32'sh0000_0000, 32'h0);
        queue_cmd(OP_LIST, 32'sd0, 32'h0);
        wait_idle();

        // capacity one, then zero, then lowered below the count
        write_capacity(7'd1);
        queue_cmd(OP_INSERT, 32'sd10, 32'h1111_0000);
        queue_cmd(OP_INSERT, 32'sd11, 32'h2222_0000);
        queue_cmd(OP_INSERT, 32'sd10, 32'h3333_0000);
        wait_idle();
        write_capacity(7'd0);
        queue_cmd(OP_INSERT, 32'sd20, 32'h4444_0000);
        queue_cmd(OP_LOOKUP, 32'sd10, 32'h0);
        wait_idle();
        write_capacity(7'd3);
        queue_cmd(OP_INSERT, 32'sd30, 32'h5555_0000);
        queue_cmd(OP_INSERT, 32'sd31, 32'h6666_0000);
        wait_idle();
        write_capacity(7'd1);
        queue_cmd(OP_INSERT, 32'sd32, 32'h7777_0000);
        queue_cmd(OP_LOOKUP, 32'sd31, 32'h0);
        wait_idle();

        // capacity above the table depth: fill the whole table and list it
        write_capacity(7'd127);
        key_pool.delete();
        key_pool.push_back(32'sd10);
        key_pool.push_back(32'sd30);
        key_pool.push_back(32'sd31);
        for (n = 0; n < 64; n++) begin
            fresh_key = $urandom;
            key_pool.push_back(fresh_key);
            queue_cmd(OP_INSERT, fresh_key, $urandom);
        end
        queue_cmd(OP_LIST, 32'sd0, 32'h0);
        wait_idle();

        // receiver holds off while the sender keeps offering
        @(posedge clk);
        gap_free = 1'b1;
        hold_requests++;
        queue_random(40, 10, 10, 15);
        wait_idle();
        @(posedge clk);
        gap_free = 1'b0;

        write_capacity(7'd64);
        queue_random(70, 15, 60, 5);
        wait_idle();

        write_capacity(7'd8);
        refresh_pool(12);
        queue_random(60, 45, 25, 10);
        wait_idle();

        // no idling on either side
        write_capacity(7'd2);
        @(posedge clk);
        gap_free   = 1'b1;
        stall_free = 1'b1;
        queue_random(45, 45, 25, 10);
        wait_idle();
        @(posedge clk);
        gap_free   = 1'b0;
        stall_free = 1'b0;

        write_capacity(7'($urandom_range(0, 127)));
        refresh_pool(20);
        queue_random(50, 40, 25, 10);
        wait_idle();

        write_capacity(7'd33);
        refresh_pool(40);
        queue_random(60, 55, 15, 8);
        wait_idle();

        write_capacity(CAP_RESET);
        queue_random(40, 35, 30, 10);
        wait_idle();

        repeat (DRAIN_WAIT) @(posedge clk);
        $display("run covered %0d transactions in (%0d lists) and %0d results checked",
                 items_accepted, lists_accepted, results_checked);
        $display("capacities from zero through above depth, full, empty and duplicate cases");
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
